FILE: src/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the complex soft-threshold core
// Sample widths, pipeline word widths and the side-band structs that travel
// alongside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int THR_WIDTH    = 16;
  localparam int SQ_WIDTH     = 2 * SAMPLE_WIDTH;
  localparam int REM_WIDTH    = SAMPLE_WIDTH + 2;
  localparam int CMP_WIDTH    = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

  typedef logic [SAMPLE_WIDTH-1:0] size_t;
  typedef logic [THR_WIDTH-1:0]    thr_t;
  typedef logic [SQ_WIDTH-1:0]     sq_t;
  typedef logic [REM_WIDTH-1:0]    rem_t;
  typedef logic [CMP_WIDTH-1:0]    cmp_t;

  // carried next to the square-root pipeline
  typedef struct packed {
    logic  neg_re;
    logic  neg_im;
    size_t size_re;
    size_t size_im;
  } sqrt_tag_t;

  // carried next to the divider pipeline
  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic zeroed;
  } div_tag_t;

endpackage

`default_nettype wire

FILE: src/cst_sqrt.sv
// ----------------------------------------------------------------------------
// cst_sqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire cst_pkg::sq_t         x,
  input  wire cst_pkg::sqrt_tag_t   tag_in,
  output logic                      out_valid,
  output cst_pkg::size_t            root,
  output cst_pkg::sqrt_tag_t        tag_out
);

  localparam int N = cst_pkg::SAMPLE_WIDTH;

  logic [N:0]          vld;
  cst_pkg::sq_t        xs   [0:N];
  cst_pkg::rem_t       rem  [0:N];
  cst_pkg::size_t      rt   [0:N];
  cst_pkg::sqrt_tag_t  tag  [0:N];

  assign vld[0] = in_valid;
  assign xs[0]  = x;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign tag[0] = tag_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    cst_pkg::rem_t cur;
    cst_pkg::rem_t trial;

    // bring down the next two radicand bits, try 4*root+1
    assign cur   = {rem[k][cst_pkg::REM_WIDTH-3:0], xs[k][cst_pkg::SQ_WIDTH-1 -: 2]};
    assign trial = {rt[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1]  <= {xs[k][cst_pkg::SQ_WIDTH-3:0], 2'b00};
        tag[k+1] <= tag[k];
        if (cur >= trial) begin
          rem[k+1] <= cur - trial;
          rt[k+1]  <= {rt[k][N-2:0], 1'b1};
        end else begin
          rem[k+1] <= cur;
          rt[k+1]  <= {rt[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N];
  assign tag_out   = tag[N];

endmodule

`default_nettype wire

FILE: src/cst_div.sv
// ----------------------------------------------------------------------------
// cst_div: pipelined dual restoring divider
// Divides two products by a shared divisor, one quotient bit per stage.
// Quotients are known to fit in SAMPLE_WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire cst_pkg::sq_t        num_re,
  input  wire cst_pkg::sq_t        num_im,
  input  wire cst_pkg::size_t      den,
  input  wire cst_pkg::div_tag_t   tag_in,
  output logic                     out_valid,
  output cst_pkg::size_t           quo_re,
  output cst_pkg::size_t           quo_im,
  output cst_pkg::div_tag_t        tag_out
);

  localparam int N = cst_pkg::SAMPLE_WIDTH;

  logic [N:0]          vld;
  cst_pkg::size_t      rem_re [0:N];
  cst_pkg::size_t      rem_im [0:N];
  cst_pkg::size_t      low_re [0:N];  // dividend bits out, quotient bits in
  cst_pkg::size_t      low_im [0:N];
  cst_pkg::size_t      dv     [0:N];
  cst_pkg::div_tag_t   tag    [0:N];

  assign vld[0]    = in_valid;
  assign rem_re[0] = num_re[cst_pkg::SQ_WIDTH-1:N];
  assign rem_im[0] = num_im[cst_pkg::SQ_WIDTH-1:N];
  assign low_re[0] = num_re[N-1:0];
  assign low_im[0] = num_im[N-1:0];
  assign dv[0]     = den;
  assign tag[0]    = tag_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0] cur_re;
    logic [N:0] cur_im;
    logic       ge_re;
    logic       ge_im;
    logic [N:0] sub_re;
    logic [N:0] sub_im;

    assign cur_re = {rem_re[k], low_re[k][N-1]};
    assign cur_im = {rem_im[k], low_im[k][N-1]};
    assign ge_re  = cur_re >= {1'b0, dv[k]};
    assign ge_im  = cur_im >= {1'b0, dv[k]};
    assign sub_re = cur_re - {1'b0, dv[k]};
    assign sub_im = cur_im - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1]     <= dv[k];
        tag[k+1]    <= tag[k];
        rem_re[k+1] <= ge_re ? sub_re[N-1:0] : cur_re[N-1:0];
        rem_im[k+1] <= ge_im ? sub_im[N-1:0] : cur_im[N-1:0];
        low_re[k+1] <= {low_re[k][N-2:0], ge_re};
        low_im[k+1] <= {low_im[k][N-2:0], ge_im};
      end
    end
  end

  assign out_valid = vld[N];
  assign quo_re    = low_re[N];
  assign quo_im    = low_im[N];
  assign tag_out   = tag[N];

endmodule

`default_nettype wire

FILE: src/complex_soft_threshold_core.sv
// ----------------------------------------------------------------------------
// complex_soft_threshold_core: streaming complex soft thresholding
// Shrinks each complex sample's magnitude by a programmable threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries sample_re, sample_im.
//   Output channel (out_valid / out_stall) returns shrunk_re, shrunk_im and
//   zeroed, one result per sample, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes the threshold;
//   cfg_ready is always high. Write it only while the pipeline is empty.
//   The stages are abs, square, sum, one stage per root bit in the square
//   root, difference, multiply, one stage per quotient bit in the divider,
//   and the output register. Throughput is one sample per cycle unless
//   out_stall holds a waiting result; every stage is fully pipelined.
//   When out_stall holds a waiting result, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and sets the threshold to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_soft_threshold_core (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic signed [cst_pkg::SAMPLE_WIDTH-1:0]   sample_re,
  input  wire logic signed [cst_pkg::SAMPLE_WIDTH-1:0]   sample_im,
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic signed [cst_pkg::SAMPLE_WIDTH-1:0]        shrunk_re,
  output logic signed [cst_pkg::SAMPLE_WIDTH-1:0]        shrunk_im,
  output logic                                           zeroed,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [cst_pkg::THR_WIDTH-1:0]             cfg_data
);

  logic en;
  cst_pkg::thr_t threshold;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // stage 1: sign and size
  logic               s1_valid;
  cst_pkg::sqrt_tag_t s1_tag;
  // stage 2: squares
  logic               s2_valid;
  cst_pkg::sqrt_tag_t s2_tag;
  cst_pkg::sq_t       s2_sq_re;
  cst_pkg::sq_t       s2_sq_im;
  // stage 3: sum of squares
  logic               s3_valid;
  cst_pkg::sqrt_tag_t s3_tag;
  cst_pkg::sq_t       s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // most negative value maps to 2^(W-1), which fits unsigned
      s1_tag.neg_re  <= sample_re[cst_pkg::SAMPLE_WIDTH-1];
      s1_tag.neg_im  <= sample_im[cst_pkg::SAMPLE_WIDTH-1];
      s1_tag.size_re <= sample_re[cst_pkg::SAMPLE_WIDTH-1] ?
                        cst_pkg::size_t'(~sample_re + 1'b1) : cst_pkg::size_t'(sample_re);
      s1_tag.size_im <= sample_im[cst_pkg::SAMPLE_WIDTH-1] ?
                        cst_pkg::size_t'(~sample_im + 1'b1) : cst_pkg::size_t'(sample_im);
      s2_tag   <= s1_tag;
      s2_sq_re <= cst_pkg::sq_t'(s1_tag.size_re) * cst_pkg::sq_t'(s1_tag.size_re);
      s2_sq_im <= cst_pkg::sq_t'(s1_tag.size_im) * cst_pkg::sq_t'(s1_tag.size_im);
      s3_tag   <= s2_tag;
      s3_sum   <= s2_sq_re + s2_sq_im;
    end
  end

  logic               rt_valid;
  cst_pkg::size_t     rt_mag;
  cst_pkg::sqrt_tag_t rt_tag;

  cst_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .x         (s3_sum),
    .tag_in    (s3_tag),
    .out_valid (rt_valid),
    .root      (rt_mag),
    .tag_out   (rt_tag)
  );

  // stage 4: compare and difference
  logic               s4_valid;
  cst_pkg::div_tag_t  s4_tag;
  cst_pkg::size_t     s4_diff;
  cst_pkg::size_t     s4_mag;
  cst_pkg::size_t     s4_size_re;
  cst_pkg::size_t     s4_size_im;
  // stage 5: products
  logic               s5_valid;
  cst_pkg::div_tag_t  s5_tag;
  cst_pkg::size_t     s5_mag;
  cst_pkg::sq_t       s5_prod_re;
  cst_pkg::sq_t       s5_prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= rt_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag.neg_re <= rt_tag.neg_re;
      s4_tag.neg_im <= rt_tag.neg_im;
      s4_tag.zeroed <= cst_pkg::cmp_t'(rt_mag) <= cst_pkg::cmp_t'(threshold);
      // only used when mag > threshold, so it fits the sample width
      s4_diff       <= cst_pkg::size_t'(cst_pkg::cmp_t'(rt_mag) - cst_pkg::cmp_t'(threshold));
      s4_mag        <= rt_mag;
      s4_size_re    <= rt_tag.size_re;
      s4_size_im    <= rt_tag.size_im;
      s5_tag        <= s4_tag;
      s5_mag        <= s4_mag;
      s5_prod_re    <= cst_pkg::sq_t'(s4_size_re) * cst_pkg::sq_t'(s4_diff);
      s5_prod_im    <= cst_pkg::sq_t'(s4_size_im) * cst_pkg::sq_t'(s4_diff);
    end
  end

  logic              dv_valid;
  cst_pkg::size_t    dv_quo_re;
  cst_pkg::size_t    dv_quo_im;
  cst_pkg::div_tag_t dv_tag;

  cst_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num_re    (s5_prod_re),
    .num_im    (s5_prod_im),
    .den       (s5_mag),
    .tag_in    (s5_tag),
    .out_valid (dv_valid),
    .quo_re    (dv_quo_re),
    .quo_im    (dv_quo_im),
    .tag_out   (dv_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zeroed <= dv_tag.zeroed;
      if (dv_tag.zeroed) begin
        shrunk_re <= '0;
        shrunk_im <= '0;
      end else begin
        shrunk_re <= dv_tag.neg_re ? cst_pkg::size_t'(~dv_quo_re + 1'b1) : dv_quo_re;
        shrunk_im <= dv_tag.neg_im ? cst_pkg::size_t'(~dv_quo_im + 1'b1) : dv_quo_im;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker: port-level checks for the complex soft-threshold core
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_checker (
  input wire logic                                     clk,
  input wire logic                                     rst,
  input wire logic                                     in_stall,
  input wire logic                                     out_valid,
  input wire logic                                     out_stall,
  input wire logic signed [cst_pkg::SAMPLE_WIDTH-1:0]  shrunk_re,
  input wire logic signed [cst_pkg::SAMPLE_WIDTH-1:0]  shrunk_im,
  input wire logic                                     zeroed,
  input wire logic                                     cfg_ready
);

  // a zeroed result carries zero parts
  a_zeroed_parts: assert property (@(posedge clk) disable iff (rst)
    out_valid && zeroed |-> shrunk_re == '0 && shrunk_im == '0)
    else $error("zeroed result with nonzero parts");

  // input backs up exactly when a waiting result is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shrunk_re) && $stable(shrunk_im)
      && $stable(zeroed))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind complex_soft_threshold_core cst_checker u_cst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .shrunk_re (shrunk_re),
  .shrunk_im (shrunk_im),
  .zeroed    (zeroed),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: dv/complex_soft_threshold_core_tb.sv
// ----------------------------------------------------------------------------
// complex_soft_threshold_core_tb: self-checking bench for the shrink core
// Streams directed and random complex samples under several thresholds,
// predicts each shrunk result in the bench and compares the outputs in order.
// Random idling on both channels, drain pauses, and an idle window before
// every threshold write.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_soft_threshold_core_tb;

  localparam int LATENCY = 2 * cst_pkg::SAMPLE_WIDTH + 6;

  typedef logic signed [cst_pkg::SAMPLE_WIDTH-1:0] part_t;

  typedef struct packed {
    logic signed [cst_pkg::SAMPLE_WIDTH-1:0] re;
    logic signed [cst_pkg::SAMPLE_WIDTH-1:0] im;
  } sample_t;

  typedef struct packed {
    logic signed [cst_pkg::SAMPLE_WIDTH-1:0] re;
    logic signed [cst_pkg::SAMPLE_WIDTH-1:0] im;
    logic                                    zeroed;
  } shrunk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [cst_pkg::SAMPLE_WIDTH-1:0] sample_re = '0;
  logic signed [cst_pkg::SAMPLE_WIDTH-1:0] sample_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cst_pkg::SAMPLE_WIDTH-1:0] shrunk_re;
  logic signed [cst_pkg::SAMPLE_WIDTH-1:0] shrunk_im;
  logic zeroed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cst_pkg::thr_t cfg_data = '0;

  complex_soft_threshold_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_re(sample_re), .sample_im(sample_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .shrunk_re(shrunk_re), .shrunk_im(shrunk_im), .zeroed(zeroed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  sample_t       pending_samples[$];
  shrunk_t       expected_shrunk[$];
  cst_pkg::thr_t shrink_thr = '0;
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic          in_taken = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic shrunk_t shrink_sample(sample_t s, cst_pkg::thr_t thr);
    shrunk_t r;
    logic [63:0] ar, ai, mag, qr, qi;
    ar = (s.re < 0) ? 64'(-64'(s.re)) : 64'(s.re);
    ai = (s.im < 0) ? 64'(-64'(s.im)) : 64'(s.im);
    mag = isqrt(ar * ar + ai * ai);
    r = '0;
    if (mag > 64'(thr)) begin
      qr = (ar * (mag - 64'(thr))) / mag;
      qi = (ai * (mag - 64'(thr))) / mag;
      if (s.re < 0) qr = -qr;
      if (s.im < 0) qi = -qi;
      r.re = qr[cst_pkg::SAMPLE_WIDTH-1:0];
      r.im = qi[cst_pkg::SAMPLE_WIDTH-1:0];
    end else begin
      r.zeroed = 1'b1;
    end
    return r;
  endfunction

  // driver: a request stays on the bus until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          sample_re <= pending_samples[0].re;
          sample_im <= pending_samples[0].im;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // pop on accept, predict at the same edge
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_shrunk.push_back(shrink_sample({sample_re, sample_im}, shrink_thr));
      void'(pending_samples.pop_front());
      in_taken = 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    shrunk_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_shrunk.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d zeroed=%0b",
                 $time, shrunk_re, shrunk_im, zeroed);
        errors++;
      end else begin
        exp_r = expected_shrunk.pop_front();
        if (shrunk_re !== exp_r.re) begin
          $display("%0t: shrunk_re expected %0d actual %0d", $time, exp_r.re, shrunk_re);
          errors++;
        end
        if (shrunk_im !== exp_r.im) begin
          $display("%0t: shrunk_im expected %0d actual %0d", $time, exp_r.im, shrunk_im);
          errors++;
        end
        if (zeroed !== exp_r.zeroed) begin
          $display("%0t: zeroed expected %0b actual %0b", $time, exp_r.zeroed, zeroed);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_shrunk.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(cst_pkg::thr_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shrink_thr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t rand_sample(int kind);
    sample_t s;
    s.re = part_t'($urandom);
    s.im = part_t'($urandom);
    if (kind == 1) begin
      // small values land near the threshold
      s.re = part_t'($signed($urandom_range(2047)) - 1024);
      s.im = part_t'($signed($urandom_range(2047)) - 1024);
    end else if (kind == 2) begin
      if ($urandom_range(1) != 0) s.re = '0; else s.im = '0;
    end
    return s;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      pending_samples.push_back(rand_sample(int'($urandom_range(2))));
  endtask

  initial begin
    cst_pkg::thr_t thr_list[6];
    part_t edge_vals[5];
    thr_list = '{16'h0000, 16'hFFFF, 16'h4000, 16'h0200, 16'h8000, 16'h0001};
    edge_vals = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sh0001};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes under reset threshold
    foreach (edge_vals[i])
      foreach (edge_vals[j])
        pending_samples.push_back(sample_t'{edge_vals[i], edge_vals[j]});
    wait_drained();

    write_threshold(16'h4000);
    pending_samples.push_back(sample_t'{16'sh4000, 16'sh0000});  // exactly at threshold
    pending_samples.push_back(sample_t'{16'sh4001, 16'sh0000});
    pending_samples.push_back(sample_t'{16'sh3000, 16'sh2000});
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thr_list[ph]);
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 86 : 0;
      recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 27 : 0;
      random_phase(85);
      // sender holds off until the pipe is empty
      while (pending_samples.size() != 0 || in_valid) @(posedge clk);
      while (expected_shrunk.size() != 0) @(posedge clk);
      write_threshold(cst_pkg::thr_t'($urandom));
      random_phase(85);
      wait_drained();
    end

    if (errors == 0)
      $display("complex_soft_threshold_core_tb: done, clean");
    else
      $display("complex_soft_threshold_core_tb: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("complex_soft_threshold_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: complex_soft_threshold_core.f
src/cst_pkg.sv
src/cst_sqrt.sv
src/cst_div.sv
src/complex_soft_threshold_core.sv
src/cst_checker.sv
dv/complex_soft_threshold_core_tb.sv
